>>> sv/ghs_pkg.sv
// Shared types and constants for the GPIB three-wire handshake engine.
`default_nettype none

package ghs_pkg;

  // Configuration port geometry: one 32-bit register at byte address 0.
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned TimeoutW = 8;

  // Register word index, taken from the address bit above the byte offset.
  localparam logic RegTimeout = 1'b0;

  // Timeout count after reset.
  localparam logic [TimeoutW-1:0] TimeoutReset = 8'd5;

  // Request codes carried in the operation field.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_SEND = 2'd1,
    OP_RECV = 2'd2
  } op_e;

  // Completion codes.
  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_NDAC_TO     = 3'd1,
    STATUS_NRFD_TO     = 3'd2,
    STATUS_DAV_ASRT_TO = 3'd3,
    STATUS_DAV_REL_TO  = 3'd4
  } status_e;

  // Handshake phases.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TX_NDAC = 3'd1,
    PH_TX_NRFD = 3'd2,
    PH_TX_REL  = 3'd3,
    PH_RX_DAV  = 3'd4,
    PH_RX_REL  = 3'd5
  } phase_e;

  // Bus line drives; a 1 pulls the line low.
  typedef struct packed {
    logic atn;
    logic eoi;
    logic ndac;
    logic nrfd;
    logic dav;
  } line_drives_t;

  // One input beat.
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       attention;
    logic       time_tick;
    logic       dav_line;
    logic       nrfd_line;
    logic       ndac_line;
    logic       eoi_line;
    logic [7:0] data_lines;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic       drive_dav;
    logic       drive_nrfd;
    logic       drive_ndac;
    logic       drive_eoi;
    logic       drive_atn;
    logic [7:0] drive_data;
    logic [7:0] rx_byte;
    logic       rx_end;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
  } out_item_t;

endpackage

`default_nettype wire

>>> sv/ghs_apb_regs.sv
// APB register file holding the handshake timeout count.
`default_nettype none

module ghs_apb_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ghs_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [ghs_pkg::ApbDataW-1:0]  pwdata,
  output logic      [ghs_pkg::ApbDataW-1:0]  prdata,
  output logic                               pready,
  output logic      [ghs_pkg::TimeoutW-1:0]  timeout_o
);
  import ghs_pkg::*;

  logic [TimeoutW-1:0] timeout_q;
  logic                wr_en;
  logic                sel_timeout;

  // The word index is the address bit above the byte offset.
  assign sel_timeout = (paddr[ApbAddrW-1] == RegTimeout);
  assign wr_en       = psel & penable & pwrite & pready;
  assign pready      = 1'b1;

  // Timeout register write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (wr_en && sel_timeout) begin
      timeout_q <= pwdata[TimeoutW-1:0];
    end
  end

  // Read back; unmapped words read as zero.
  always_comb begin
    prdata = '0;
    if (sel_timeout) begin
      prdata[TimeoutW-1:0] = timeout_q;
    end
  end

  assign timeout_o = timeout_q;

endmodule

`default_nettype wire

>>> sv/ghs_engine.sv
// Handshake state machine: phase, wait counter, held byte and line drives.
`default_nettype none

module ghs_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire ghs_pkg::in_item_t            item_i,
  input  wire logic [ghs_pkg::TimeoutW-1:0] timeout_i,
  output ghs_pkg::out_item_t                result_o
);
  import ghs_pkg::*;

  phase_e              phase_q, phase_d;
  logic [TimeoutW-1:0] wait_q, wait_d;
  logic [7:0]          byte_q, byte_d;
  logic                end_q, end_d;
  logic                last_q, last_d;
  logic                att_q, att_d;
  line_drives_t        drives_q, drives_d;

  logic                dav_low, nrfd_low, ndac_low;
  logic                expired;
  logic                done;
  status_e             status;
  logic [7:0]          rx_byte;
  logic                rx_end;

  assign dav_low  = ~item_i.dav_line;
  assign nrfd_low = ~item_i.nrfd_line;
  assign ndac_low = ~item_i.ndac_line;

  // A wait runs out once the count has reached the programmed limit.
  assign expired = (wait_q >= timeout_i);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: begin
        if (item_i.operation == OP_SEND) begin
          phase_d = PH_TX_NDAC;
        end else if (item_i.operation == OP_RECV) begin
          phase_d = PH_RX_DAV;
        end
      end
      PH_TX_NDAC: begin
        if (ndac_low) begin
          phase_d = PH_TX_NRFD;
        end else if (expired) begin
          phase_d = PH_IDLE;
        end
      end
      PH_TX_NRFD: begin
        if (!nrfd_low) begin
          phase_d = PH_TX_REL;
        end else if (expired) begin
          phase_d = PH_IDLE;
        end
      end
      PH_TX_REL: begin
        if (!ndac_low) begin
          phase_d = PH_IDLE;
        end
      end
      PH_RX_DAV: begin
        if (dav_low) begin
          phase_d = PH_RX_REL;
        end else if (expired) begin
          phase_d = PH_IDLE;
        end
      end
      PH_RX_REL: begin
        if (!dav_low || expired) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Line drives, wait counter, held data and completion flags.
  always_comb begin
    drives_d = drives_q;
    wait_d   = wait_q;
    byte_d   = byte_q;
    end_d    = end_q;
    last_d   = last_q;
    att_d    = att_q;
    done     = 1'b0;
    status   = STATUS_OK;
    rx_byte  = '0;
    rx_end   = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (item_i.operation == OP_SEND) begin
          byte_d       = item_i.tx_byte;
          last_d       = item_i.tx_last;
          att_d        = item_i.attention;
          drives_d     = '0;
          drives_d.atn = item_i.attention;
          wait_d       = '0;
        end else if (item_i.operation == OP_RECV) begin
          drives_d.ndac = 1'b1;
          drives_d.nrfd = 1'b0;
          wait_d        = '0;
        end
      end
      PH_TX_NDAC: begin
        if (ndac_low) begin
          drives_d.nrfd = 1'b0;
          wait_d        = '0;
        end else if (expired) begin
          done   = 1'b1;
          status = STATUS_NDAC_TO;
        end else if (item_i.time_tick) begin
          wait_d = wait_q + 1'b1;
        end
      end
      PH_TX_NRFD: begin
        if (!nrfd_low) begin
          if (last_q && !att_q) begin
            drives_d.eoi = 1'b1;
          end
          drives_d.dav = 1'b1;
        end else if (expired) begin
          done   = 1'b1;
          status = STATUS_NRFD_TO;
        end else if (item_i.time_tick) begin
          wait_d = wait_q + 1'b1;
        end
      end
      PH_TX_REL: begin
        // The release wait of a send is not bounded.
        if (!ndac_low) begin
          done = 1'b1;
        end
      end
      PH_RX_DAV: begin
        if (dav_low) begin
          drives_d.nrfd = 1'b1;
          drives_d.ndac = 1'b0;
          byte_d        = ~item_i.data_lines;
          end_d         = ~item_i.eoi_line;
          wait_d        = '0;
        end else if (expired) begin
          done   = 1'b1;
          status = STATUS_DAV_ASRT_TO;
        end else if (item_i.time_tick) begin
          wait_d = wait_q + 1'b1;
        end
      end
      PH_RX_REL: begin
        if (!dav_low) begin
          drives_d.ndac = 1'b1;
          rx_byte       = byte_q;
          rx_end        = end_q;
          done          = 1'b1;
        end else if (expired) begin
          done   = 1'b1;
          status = STATUS_DAV_REL_TO;
        end else if (item_i.time_tick) begin
          wait_d = wait_q + 1'b1;
        end
      end
      default: begin
      end
    endcase

    // A finished or failed send lets go of DAV and ATN; EOI keeps its level.
    if (done) begin
      if (phase_q inside {PH_TX_NDAC, PH_TX_NRFD, PH_TX_REL}) begin
        drives_d.dav = 1'b0;
        drives_d.atn = 1'b0;
      end
      wait_d = '0;
    end
  end

  // State registers advance once per beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      wait_q   <= '0;
      byte_q   <= '0;
      end_q    <= 1'b0;
      last_q   <= 1'b0;
      att_q    <= 1'b0;
      drives_q <= '{atn: 1'b0, eoi: 1'b0, ndac: 1'b0, nrfd: 1'b1, dav: 1'b0};
    end else if (step_i) begin
      phase_q  <= phase_d;
      wait_q   <= wait_d;
      byte_q   <= byte_d;
      end_q    <= end_d;
      last_q   <= last_d;
      att_q    <= att_d;
      drives_q <= drives_d;
    end
  end

  // Result beat, built from the updated state.
  always_comb begin
    result_o.drive_dav  = drives_d.dav;
    result_o.drive_nrfd = drives_d.nrfd;
    result_o.drive_ndac = drives_d.ndac;
    result_o.drive_eoi  = drives_d.eoi;
    result_o.drive_atn  = drives_d.atn;
    result_o.drive_data = (phase_d inside {PH_TX_NRFD, PH_TX_REL}) ? byte_d : 8'h00;
    result_o.rx_byte    = rx_byte;
    result_o.rx_end     = rx_end;
    result_o.busy_res   = (phase_d != PH_IDLE);
    result_o.done_res   = done;
    result_o.status     = status;
  end

endmodule

`default_nettype wire

>>> sv/gpib_three_wire_handshake.sv
// Top level of the GPIB three-wire handshake engine with input and result registers.
//
//   Channel   Direction  Handshake                 Payload
//   --------  ---------  ------------------------  -------------------------
//   in        sink       in_valid_i / in_stall_o   in_item_i  (in_item_t)
//   out       source     out_valid_o / out_stall_i out_item_o (out_item_t)
//   config    APB slave  psel, penable, pready     timeout_ticks at address 0
//
// Each beat is held in the input register, then the state machine steps and
// the result is registered. A new beat is accepted in every cycle while
// results keep draining. A stalled result holds the engine and, once the
// input register is full, stalls the input side. Reset releases all lines
// except NRFD.
`default_nettype none

module gpib_three_wire_handshake (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire ghs_pkg::in_item_t            in_item_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output ghs_pkg::out_item_t                out_item_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ghs_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [ghs_pkg::ApbDataW-1:0] pwdata,
  output logic      [ghs_pkg::ApbDataW-1:0] prdata,
  output logic                              pready
);
  import ghs_pkg::*;

  logic                in_valid_q;
  in_item_t            in_item_q;
  logic                out_valid_q;
  out_item_t           out_item_q;
  out_item_t           result;
  logic                step;
  logic [TimeoutW-1:0] timeout;

  // The held beat steps the engine when the result register can take it.
  assign step       = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  ghs_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .timeout_o (timeout)
  );

  ghs_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_item_q),
    .timeout_i (timeout),
    .result_o  (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

>>> tb/sv/tb_gpib_three_wire_handshake.sv
// Self-checking testbench for the GPIB three-wire handshake engine.
`timescale 1ns / 100ps

module tb_gpib_three_wire_handshake;
  import ghs_pkg::*;

  // Operation code that the engine must ignore.
  localparam logic [1:0] OpReserved = 2'd3;
  localparam int NumPhases = 7;
  localparam int BeatsPerPhase = 133;

  // One row of the directed table.
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_item_t in_item_i;
  logic out_valid_o;
  logic out_stall_i;
  out_item_t out_item_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  // Predicted engine state and its copy of the timeout register.
  logic [TimeoutW-1:0] tick_limit;
  phase_e              hs_phase;
  logic [7:0]          tick_count;
  logic [7:0]          latched_byte;
  logic                latched_end;
  logic                latched_last;
  logic                latched_atn;
  line_drives_t        bus_drives;

  out_item_t predicted_beats[$];
  dir_row_t  dir_rows[$];
  int        mismatches = 0;
  int        gap_pct = 15;
  int        stall_pct = 15;
  int        stall_left = 0;
  int        patience = 50;

  gpib_three_wire_handshake u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Returns 1 when the current wait has run out; otherwise counts a tick.
  function automatic logic wait_ran_out(logic tick);
    if (tick_count >= tick_limit) return 1'b1;
    if (tick) tick_count = tick_count + 8'd1;
    return 1'b0;
  endfunction

  // Advances the predicted engine by one beat and returns the expected result.
  function automatic out_item_t engine_step(in_item_t b);
    out_item_t r;
    logic fin;
    logic [2:0] code;
    r = '0;
    fin = 1'b0;
    code = STATUS_OK;
    case (hs_phase)
      PH_IDLE: begin
        if (b.operation == OP_SEND) begin
          latched_byte = b.tx_byte;
          latched_last = b.tx_last;
          latched_atn = b.attention;
          bus_drives = '0;
          bus_drives.atn = b.attention;
          tick_count = '0;
          hs_phase = PH_TX_NDAC;
        end else if (b.operation == OP_RECV) begin
          bus_drives.ndac = 1'b1;
          bus_drives.nrfd = 1'b0;
          tick_count = '0;
          hs_phase = PH_RX_DAV;
        end
      end
      PH_TX_NDAC: begin
        if (!b.ndac_line) begin
          bus_drives.nrfd = 1'b0;
          tick_count = '0;
          hs_phase = PH_TX_NRFD;
        end else if (wait_ran_out(b.time_tick)) begin
          fin = 1'b1;
          code = STATUS_NDAC_TO;
        end
      end
      PH_TX_NRFD: begin
        if (b.nrfd_line) begin
          if (latched_last && !latched_atn) bus_drives.eoi = 1'b1;
          bus_drives.dav = 1'b1;
          hs_phase = PH_TX_REL;
        end else if (wait_ran_out(b.time_tick)) begin
          fin = 1'b1;
          code = STATUS_NRFD_TO;
        end
      end
      PH_TX_REL: begin
        // The final NDAC release wait is unbounded.
        if (b.ndac_line) fin = 1'b1;
      end
      PH_RX_DAV: begin
        if (!b.dav_line) begin
          bus_drives.nrfd = 1'b1;
          bus_drives.ndac = 1'b0;
          latched_byte = ~b.data_lines;
          latched_end = !b.eoi_line;
          tick_count = '0;
          hs_phase = PH_RX_REL;
        end else if (wait_ran_out(b.time_tick)) begin
          fin = 1'b1;
          code = STATUS_DAV_ASRT_TO;
        end
      end
      PH_RX_REL: begin
        if (b.dav_line) begin
          bus_drives.ndac = 1'b1;
          r.rx_byte = latched_byte;
          r.rx_end = latched_end;
          fin = 1'b1;
        end else if (wait_ran_out(b.time_tick)) begin
          fin = 1'b1;
          code = STATUS_DAV_REL_TO;
        end
      end
      default: hs_phase = PH_IDLE;
    endcase

    // A finished or failed send drops DAV, the data and ATN; EOI stays.
    if (fin) begin
      if (hs_phase == PH_TX_NDAC || hs_phase == PH_TX_NRFD || hs_phase == PH_TX_REL) begin
        bus_drives.dav = 1'b0;
        bus_drives.atn = 1'b0;
      end
      hs_phase = PH_IDLE;
      tick_count = '0;
    end

    r.drive_dav = bus_drives.dav;
    r.drive_nrfd = bus_drives.nrfd;
    r.drive_ndac = bus_drives.ndac;
    r.drive_eoi = bus_drives.eoi;
    r.drive_atn = bus_drives.atn;
    r.drive_data = (hs_phase == PH_TX_NRFD || hs_phase == PH_TX_REL) ? latched_byte : 8'h00;
    r.busy_res = (hs_phase != PH_IDLE);
    r.done_res = fin;
    r.status = code;
    return r;
  endfunction

  // Builds one input beat; lines packs dav, nrfd, ndac and eoi levels.
  function automatic in_item_t make_item(logic [1:0] op, logic [7:0] txb, logic last,
                                         logic attn, logic tick, logic [3:0] lines,
                                         logic [7:0] data);
    in_item_t b;
    b.operation = op;
    b.tx_byte = txb;
    b.tx_last = last;
    b.attention = attn;
    b.time_tick = tick;
    {b.dav_line, b.nrfd_line, b.ndac_line, b.eoi_line} = lines;
    b.data_lines = data;
    return b;
  endfunction

  // Random beat whose awaited bus line is ready with the current patience.
  function automatic in_item_t random_item();
    in_item_t b;
    logic ready;
    int unsigned pick;
    b = make_item(OP_NONE, 8'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom), 4'($urandom), 8'($urandom));
    pick = $urandom_range(0, 99);
    if (hs_phase == PH_IDLE) begin
      if (pick < 42) b.operation = OP_SEND;
      else if (pick < 84) b.operation = OP_RECV;
      else if (pick < 95) b.operation = OP_NONE;
      else b.operation = OpReserved;
    end else if (pick < 10) begin
      b.operation = 2'($urandom);
    end
    ready = ($urandom_range(0, 99) < patience);
    case (hs_phase)
      PH_TX_NDAC: b.ndac_line = !ready;
      PH_TX_NRFD: b.nrfd_line = ready;
      PH_TX_REL:  b.ndac_line = ready;
      PH_RX_DAV:  b.dav_line = !ready;
      PH_RX_REL:  b.dav_line = ready;
      default: ;
    endcase
    return b;
  endfunction

  // Field-by-field comparison of a result beat.
  function automatic void check_beat(out_item_t got, out_item_t want);
    if (got.drive_dav !== want.drive_dav) begin
      $error("drive_dav: expected %0h, got %0h", want.drive_dav, got.drive_dav);
      mismatches++;
    end
    if (got.drive_nrfd !== want.drive_nrfd) begin
      $error("drive_nrfd: expected %0h, got %0h", want.drive_nrfd, got.drive_nrfd);
      mismatches++;
    end
    if (got.drive_ndac !== want.drive_ndac) begin
      $error("drive_ndac: expected %0h, got %0h", want.drive_ndac, got.drive_ndac);
      mismatches++;
    end
    if (got.drive_eoi !== want.drive_eoi) begin
      $error("drive_eoi: expected %0h, got %0h", want.drive_eoi, got.drive_eoi);
      mismatches++;
    end
    if (got.drive_atn !== want.drive_atn) begin
      $error("drive_atn: expected %0h, got %0h", want.drive_atn, got.drive_atn);
      mismatches++;
    end
    if (got.drive_data !== want.drive_data) begin
      $error("drive_data: expected %0h, got %0h", want.drive_data, got.drive_data);
      mismatches++;
    end
    if (got.rx_byte !== want.rx_byte) begin
      $error("rx_byte: expected %0h, got %0h", want.rx_byte, got.rx_byte);
      mismatches++;
    end
    if (got.rx_end !== want.rx_end) begin
      $error("rx_end: expected %0h, got %0h", want.rx_end, got.rx_end);
      mismatches++;
    end
    if (got.busy_res !== want.busy_res) begin
      $error("busy_res: expected %0h, got %0h", want.busy_res, got.busy_res);
      mismatches++;
    end
    if (got.done_res !== want.done_res) begin
      $error("done_res: expected %0h, got %0h", want.done_res, got.done_res);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0h, got %0h", want.status, got.status);
      mismatches++;
    end
  endfunction

  // Result monitor and random stall bursts on the result side.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (predicted_beats.size() == 0) begin
        $error("result beat arrived with nothing expected");
        mismatches++;
      end else begin
        check_beat(out_item_o, predicted_beats.pop_front());
      end
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Offers one beat, waits for it to be taken and records its prediction.
  task automatic send_beat(in_item_t b, bit typed, out_item_t want);
    out_item_t pred;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = engine_step(b);
    predicted_beats.push_back(typed ? want : pred);
  endtask

  // Lets every outstanding result drain and the pipeline settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (predicted_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes the timeout register through the configuration port.
  task automatic write_timeout(logic [TimeoutW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {RegTimeout, 2'b00};
    pwdata <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tick_limit = value;
  endtask

  // Main sequence: reset, directed table, then random phases.
  initial begin
    out_item_t idle_res;
    out_item_t ndac_to_res;
    in_item_t b;
    int unsigned tmo_plan[NumPhases];
    int gap_plan[NumPhases];
    int stall_plan[NumPhases];
    int pats[3];
    int n;
    bit counted;

    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    out_stall_i <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    tick_limit = TimeoutReset;
    hs_phase = PH_IDLE;
    tick_count = '0;
    latched_byte = '0;
    latched_end = 1'b0;
    latched_last = 1'b0;
    latched_atn = 1'b0;
    bus_drives = '0;
    bus_drives.nrfd = 1'b1;

    // After reset only NRFD is pulled low.
    idle_res = '0;
    idle_res.drive_nrfd = 1'b1;
    // A send that never sees NDAC low fails with every line released.
    ndac_to_res = '0;
    ndac_to_res.done_res = 1'b1;
    ndac_to_res.status = STATUS_NDAC_TO;

    // Directed table: idle, reserved code, data and command sends, two
    // receives with extreme bytes, and an NDAC timeout at the reset limit.
    dir_rows.push_back('{make_item(OP_NONE, 8'h00, 0, 0, 0, 4'b1111, 8'h00), 1, idle_res});
    dir_rows.push_back('{make_item(OpReserved, 8'hff, 1, 1, 1, 4'b1111, 8'hff), 1, idle_res});
    dir_rows.push_back('{make_item(OP_SEND, 8'hff, 1, 0, 0, 4'b1111, 8'h00), 0, '0});
    dir_rows.push_back('{make_item(OP_NONE, 8'h00, 0, 0, 0, 4'b1101, 8'h00), 0, '0});
    dir_rows.push_back('{make_item(OP_NONE, 8'h00, 0, 0, 0, 4'b1111, 8'h00), 0, '0});
    dir_rows.push_back('{make_item(OP_SEND, 8'h00, 0, 0, 0, 4'b1101, 8'h00), 0, '0});
    dir_rows.push_back('{make_item(OP_NONE, 8'h00, 0, 0, 0, 4'b1111, 8'h00), 0, '0});
    dir_rows.push_back('{make_item(OP_SEND, 8'h00, 1, 1, 0, 4'b1111, 8'h00), 0, '0});
    dir_rows.push_back('{make_item(OP_NONE, 8'h00, 0, 0, 0, 4'b1101, 8'h00), 0, '0});
    dir_rows.push_back('{make_item(OP_NONE, 8'h00, 0, 0, 0, 4'b1111, 8'h00), 0, '0});
    dir_rows.push_back('{make_item(OP_NONE, 8'h00, 0, 0, 0, 4'b1111, 8'h00), 0, '0});
    dir_rows.push_back('{make_item(OP_RECV, 8'h00, 0, 0, 0, 4'b1111, 8'h00), 0, '0});
    dir_rows.push_back('{make_item(OP_NONE, 8'h00, 0, 0, 0, 4'b0110, 8'h00), 0, '0});
    dir_rows.push_back('{make_item(OP_NONE, 8'h00, 0, 0, 0, 4'b1111, 8'h00), 0, '0});
    dir_rows.push_back('{make_item(OP_RECV, 8'h00, 0, 0, 0, 4'b1111, 8'h00), 0, '0});
    dir_rows.push_back('{make_item(OP_NONE, 8'h00, 0, 0, 0, 4'b0111, 8'hff), 0, '0});
    dir_rows.push_back('{make_item(OP_NONE, 8'h00, 0, 0, 0, 4'b1111, 8'h00), 0, '0});
    dir_rows.push_back('{make_item(OP_SEND, 8'h5a, 0, 0, 0, 4'b1111, 8'h00), 0, '0});
    for (int i = 0; i < 5; i++) begin
      dir_rows.push_back('{make_item(OP_NONE, 8'h00, 0, 0, 1, 4'b1111, 8'h00), 0, '0});
    end
    dir_rows.push_back('{make_item(OP_NONE, 8'h00, 0, 0, 1, 4'b1111, 8'h00), 1, ndac_to_res});

    // Timeout settings per phase: 1, 255 and 0 first, the reset value last.
    tmo_plan = '{1, 255, 0, 3, $urandom_range(1, 255), $urandom_range(2, 12), TimeoutReset};
    gap_plan = '{20, 0, 35, 10, 25, 30, 0};
    stall_plan = '{25, 0, 15, 35, 10, 30, 0};
    pats = '{15, 45, 85};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_timeout(TimeoutW'(tmo_plan[p]));
      gap_pct = gap_plan[p];
      stall_pct = stall_plan[p];
      n = 0;
      while (n < BeatsPerPhase) begin
        // A fresh transfer gets its own bus patience.
        if (hs_phase == PH_IDLE) patience = pats[$urandom_range(0, 2)];
        b = random_item();
        counted = (hs_phase != PH_IDLE) || b.operation == OP_SEND || b.operation == OP_RECV;
        send_beat(b, 0, '0);
        if (counted) n++;
      end
    end

    drain();
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
